/* sv/cfsf_pkg.sv */
// ----------------------------------------------------------------------------
// cfsf_pkg - shared types and constants for the cylinder flow stream function
// Fixed-point formats, pipeline depths, register indexes and the structs
// that pass between the datapath units.
// ----------------------------------------------------------------------------
package cfsf_pkg;

	localparam int FRAC_BITS = 16;          // Q8.16
	localparam int W         = 24;          // field width
	localparam int WD_W      = W + 1;       // w = point - centre
	localparam int M2_W      = 2 * W + 2;   // |w|^2, |d|, |fac|
	localparam int HALF      = M2_W / 2;    // partial product split
	localparam int PROD_W    = 2 * M2_W;    // |d|*|fac|
	localparam int CAP_BITS  = 40;          // flow magnitude cap 2^40
	localparam int DIV_STEPS = CAP_BITS + 1;
	localparam int DIV_TOP   = DIV_STEPS + FRAC_BITS;
	localparam int FLOW_W    = CAP_BITS + 2;
	localparam int SQ_STEPS  = 24;          // log2 fraction bits
	localparam int MANT_FB   = 30;          // mantissa fraction bits
	localparam int MANT_W    = MANT_FB + 1;
	localparam int E_W       = 6;
	localparam int LG_W      = E_W + 1 + SQ_STEPS;
	localparam int LN2_W     = 30;
	localparam int LNP_W     = LG_W + LN2_W;
	localparam int LN_W      = 30;
	localparam int KP_W      = W + LN_W;
	localparam int LOG_SH    = 25;
	localparam int LOGT_W    = KP_W - LOG_SH;
	localparam int SUM_W     = FLOW_W + 1;
	localparam int GRP       = 8;
	localparam int NGRP      = (M2_W + GRP - 1) / GRP;

	// stage counts of the two units
	localparam int FLOW_LAT  = 6 + DIV_STEPS;
	localparam int LOG_LAT   = 7 + SQ_STEPS;
	localparam int ALIGN     = FLOW_LAT - LOG_LAT;

	localparam logic [LN2_W-1:0] LN2_Q30 = 30'd744261118;
	localparam logic signed [W-1:0] OUT_MAX = 24'sh7fffff;
	localparam logic signed [W-1:0] OUT_MIN = 24'sh800000;

	typedef enum logic [2:0] {
		REG_CENTER_RE = 3'd0,
		REG_CENTER_IM = 3'd1,
		REG_RADIUS_SQ = 3'd2,
		REG_FLOW_COS  = 3'd3,
		REG_FLOW_SIN  = 3'd4,
		REG_CIRC_K    = 3'd5
	} cfsf_reg_e;

	typedef struct packed {
		logic en;
		logic valid;
	} cfsf_ctl_t;

	typedef struct packed {
		logic        [M2_W-1:0] m2;
		logic signed [M2_W-1:0] d;
		logic signed [M2_W:0]   fac;
	} cfsf_flow_in_t;

	typedef struct packed {
		logic [M2_W-1:0] m2;
		logic            zero;
	} cfsf_log_in_t;

	typedef struct packed {
		logic signed [LOGT_W-1:0] logt;
		logic                     zero;
	} cfsf_log_out_t;

endpackage

/* sv/cfsf_ifs.sv */
// ----------------------------------------------------------------------------
// cfsf_ifs - stream channels
// Point input word and result output word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cfsf_point_if;
	logic              valid;
	logic              ready;
	logic signed [23:0] point_re;
	logic signed [23:0] point_im;
	modport source(output valid, point_re, point_im, input ready);
	modport sink(input valid, point_re, point_im, output ready);
endinterface

interface cfsf_result_if;
	logic              valid;
	logic              ready;
	logic signed [23:0] stream_value;
	logic              at_center;
	logic              clipped;
	modport source(output valid, stream_value, at_center, clipped, input ready);
	modport sink(input valid, stream_value, at_center, clipped, output ready);
endinterface

/* sv/cfsf_flow.sv */
// ----------------------------------------------------------------------------
// cfsf_flow - flow term unit
// |d|*|fac| by partial products, then a one-bit-per-stage restoring divide
// by |w|^2, scaled down by 2^FRAC_BITS and capped at 2^40.
// ----------------------------------------------------------------------------
module cfsf_flow (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cfsf_pkg::cfsf_ctl_t                 ctl,
	input  cfsf_pkg::cfsf_flow_in_t             din,
	output logic                                valid,
	output logic signed [cfsf_pkg::FLOW_W-1:0]  flow
);
	import cfsf_pkg::*;

	logic [FLOW_LAT:1] vld_s;

	logic [M2_W-1:0] dm_s1, fm_s1, m2_s1;
	logic            neg_s1;
	logic [M2_W-1:0] pp00_s2, pp01_s2, pp10_s2, pp11_s2, m2_s2;
	logic            neg_s2;
	logic [M2_W:0]   mid_s3;
	logic [PROD_W-1:0] lo_s3;
	logic [M2_W-1:0] m2_s3;
	logic            neg_s3;
	logic [PROD_W-1:0] prod_s4;
	logic [M2_W-1:0] m2_s4;
	logic            neg_s4;

	logic [M2_W-1:0]      rem_s [0:DIV_STEPS];
	logic [DIV_STEPS-1:0] nq_s  [0:DIV_STEPS];
	logic [M2_W-1:0]      dm2_s [0:DIV_STEPS];
	logic                 ovf_s [0:DIV_STEPS];
	logic                 dneg_s[0:DIV_STEPS];

	logic signed [FLOW_W-1:0] flow_s47;
	logic [DIV_STEPS-1:0]     q;
	logic [CAP_BITS:0]        mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (ctl.en) begin
			vld_s <= {vld_s[FLOW_LAT-1:1], ctl.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			// magnitudes and sign of the product
			dm_s1  <= din.d[M2_W-1] ? M2_W'(-din.d) : M2_W'(din.d);
			fm_s1  <= din.fac[M2_W] ? M2_W'(-din.fac) : M2_W'(din.fac);
			neg_s1 <= din.d[M2_W-1] ^ din.fac[M2_W];
			m2_s1  <= din.m2;
			// four partial products
			pp00_s2 <= dm_s1[HALF-1:0] * fm_s1[HALF-1:0];
			pp01_s2 <= dm_s1[HALF-1:0] * fm_s1[M2_W-1:HALF];
			pp10_s2 <= dm_s1[M2_W-1:HALF] * fm_s1[HALF-1:0];
			pp11_s2 <= dm_s1[M2_W-1:HALF] * fm_s1[M2_W-1:HALF];
			neg_s2  <= neg_s1;
			m2_s2   <= m2_s1;
			// cross terms share one weight
			mid_s3 <= {1'b0, pp01_s2} + {1'b0, pp10_s2};
			lo_s3  <= {pp11_s2, pp00_s2};
			neg_s3 <= neg_s2;
			m2_s3  <= m2_s2;
			prod_s4 <= lo_s3 + PROD_W'({mid_s3, {HALF{1'b0}}});
			neg_s4  <= neg_s3;
			m2_s4   <= m2_s3;
			// quotient >= 2^(CAP_BITS+1) after scaling: saturate
			ovf_s[0]  <= M2_W'(prod_s4[PROD_W-1:DIV_TOP]) >= m2_s4;
			rem_s[0]  <= M2_W'(prod_s4[PROD_W-1:DIV_TOP]);
			nq_s[0]   <= prod_s4[DIV_TOP-1:FRAC_BITS];
			dm2_s[0]  <= m2_s4;
			dneg_s[0] <= neg_s4;
		end
	end

	// nq holds the numerator bits still to come on top, quotient bits below
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [M2_W:0] trial;
		logic          ge;
		assign trial = {rem_s[j], nq_s[j][DIV_STEPS-1]};
		assign ge    = trial >= {1'b0, dm2_s[j]};
		always_ff @(posedge clk) begin
			if (ctl.en) begin
				rem_s[j+1]  <= ge ? M2_W'(trial - {1'b0, dm2_s[j]}) : trial[M2_W-1:0];
				nq_s[j+1]   <= {nq_s[j][DIV_STEPS-2:0], ge};
				dm2_s[j+1]  <= dm2_s[j];
				ovf_s[j+1]  <= ovf_s[j];
				dneg_s[j+1] <= dneg_s[j];
			end
		end
	end

	assign q = nq_s[DIV_STEPS];

	always_comb begin
		if (ovf_s[DIV_STEPS] || (q > (DIV_STEPS'(1) << CAP_BITS))) begin
			mag = (CAP_BITS+1)'(1) << CAP_BITS;
		end else begin
			mag = q[CAP_BITS:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			flow_s47 <= dneg_s[DIV_STEPS] ? -$signed(FLOW_W'(mag)) : $signed(FLOW_W'(mag));
		end
	end

	assign valid = vld_s[FLOW_LAT];
	assign flow  = flow_s47;

endmodule

/* sv/cfsf_log.sv */
// ----------------------------------------------------------------------------
// cfsf_log - circulation term unit
// Leading-one search and normalize, 24 square-and-compare stages for log2,
// scale by ln2, multiply by k, truncate toward zero.
// ----------------------------------------------------------------------------
module cfsf_log (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfsf_pkg::cfsf_ctl_t           ctl,
	input  logic signed [cfsf_pkg::W-1:0] circ_k,
	input  cfsf_pkg::cfsf_log_in_t        din,
	output cfsf_pkg::cfsf_log_out_t       dout
);
	import cfsf_pkg::*;

	logic [LOG_LAT:1] vld_s;

	logic [NGRP-1:0]        gnz_s1;
	logic [NGRP-1:0][2:0]   gpos_s1;
	logic [M2_W-1:0]        m2_s1, m2_s2;
	logic                   zero_s1, zero_s2;
	logic [E_W-1:0]         e_s2;

	logic [MANT_W-1:0]   sq_m_s [0:SQ_STEPS];
	logic [SQ_STEPS-1:0] sq_f_s [0:SQ_STEPS];
	logic [E_W-1:0]      sq_e_s [0:SQ_STEPS];
	logic                sq_z_s [0:SQ_STEPS];

	logic signed [LNP_W-1:0]  lnp_s28;
	logic signed [LN_W-1:0]   ln_s29;
	logic signed [KP_W-1:0]   kp_s30;
	logic signed [LOGT_W-1:0] logt_s31;
	logic                     zero_s28, zero_s29, zero_s30, zero_s31;

	logic [NGRP*GRP-1:0]    m2_pad;
	logic [NGRP-1:0]        gnz;
	logic [NGRP-1:0][2:0]   gpos;
	logic [E_W-1:0]         e;
	logic [M2_W-1:0]        norm;
	logic signed [E_W:0]    em;
	logic signed [LG_W-1:0] lg;
	logic signed [LNP_W-1:0] lnp_adj;
	logic signed [KP_W-1:0]  kp_adj;

	// valid follows the data; kept for debug visibility of the unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (ctl.en) begin
			vld_s <= {vld_s[LOG_LAT-1:1], ctl.valid};
		end
	end

	// group-wise leading one
	always_comb begin
		m2_pad = (NGRP*GRP)'(din.m2);
		for (int g = 0; g < NGRP; g++) begin
			gnz[g]  = |m2_pad[g*GRP +: GRP];
			gpos[g] = '0;
			for (int b = 0; b < GRP; b++) begin
				if (m2_pad[g*GRP + b]) begin
					gpos[g] = 3'(b);
				end
			end
		end
	end

	always_comb begin
		e = '0;
		for (int g = 0; g < NGRP; g++) begin
			if (gnz_s1[g]) begin
				e = {3'(g), gpos_s1[g]};
			end
		end
	end

	assign norm = m2_s2 << (E_W'(M2_W - 1) - e_s2);

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			gnz_s1  <= gnz;
			gpos_s1 <= gpos;
			m2_s1   <= din.m2;
			zero_s1 <= din.zero;
			e_s2    <= e;
			m2_s2   <= m2_s1;
			zero_s2 <= zero_s1;
			// mantissa in [1,2) with MANT_FB fraction bits
			sq_m_s[0] <= norm[M2_W-1 -: MANT_W];
			sq_f_s[0] <= '0;
			sq_e_s[0] <= e_s2;
			sq_z_s[0] <= zero_s2;
		end
	end

	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
		logic [2*MANT_W-1:0] sq;
		logic [MANT_W:0]     t;
		assign sq = sq_m_s[j] * sq_m_s[j];
		assign t  = sq[2*MANT_W-1:MANT_FB];
		always_ff @(posedge clk) begin
			if (ctl.en) begin
				sq_m_s[j+1] <= t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
				sq_f_s[j+1] <= {sq_f_s[j][SQ_STEPS-2:0], t[MANT_W]};
				sq_e_s[j+1] <= sq_e_s[j];
				sq_z_s[j+1] <= sq_z_s[j];
			end
		end
	end

	// log2|w|^2 = (e - 2F) + frac
	assign em = $signed({1'b0, sq_e_s[SQ_STEPS]}) - (E_W+1)'(2 * FRAC_BITS);
	assign lg = $signed({em, sq_f_s[SQ_STEPS]});

	assign lnp_adj = lnp_s28 + (lnp_s28[LNP_W-1] ? LNP_W'((64'd1 << 30) - 1) : '0);
	assign kp_adj  = kp_s30 + (kp_s30[KP_W-1] ? KP_W'((64'd1 << LOG_SH) - 1) : '0);

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			lnp_s28  <= lg * $signed({1'b0, LN2_Q30});
			zero_s28 <= sq_z_s[SQ_STEPS];
			ln_s29   <= lnp_adj[30 + LN_W - 1:30];
			zero_s29 <= zero_s28;
			kp_s30   <= circ_k * ln_s29;
			zero_s30 <= zero_s29;
			logt_s31 <= kp_adj[KP_W-1:LOG_SH];
			zero_s31 <= zero_s30;
		end
	end

	assign dout.logt = logt_s31;
	assign dout.zero = zero_s31 | (vld_s[LOG_LAT] & 1'b0);

endmodule

/* sv/cylinder_flow_stream_function_top.sv */
// ----------------------------------------------------------------------------
// cylinder_flow_stream_function_top - stream function of flow past a cylinder
// psi = (ux*wy - uy*wx)*(1 - r2/|w|^2) + k*0.5*ln|w|^2, w = point - centre,
// Q8.16, saturated to 24 bits, flagged at the centre.
//
//   channel  | dir | payload                              | handshake
//   ---------+-----+--------------------------------------+-----------
//   point    | in  | point_re, point_im                   | valid/ready
//   result   | out | stream_value, at_center, clipped     | valid/ready
//   cfg      | in  | cfg_index, cfg_data                  | cfg_we only
//
// One word in and one word out per cycle unless stalled. The pipe is 3 front
// stages plus 47 flow stages plus the output register. The 41-stage
// restoring divide sets the depth; the log path runs alongside and is
// delayed to meet it. All stages advance together while the output register
// is empty or being taken; a stall freezes them all. Reset clears valid bits
// and loads the register defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
module cylinder_flow_stream_function_top (
	input  logic                clk,
	input  logic                arst_n,
	cfsf_point_if.sink          point,
	cfsf_result_if.source       result,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [23:0]         cfg_data
);
	import cfsf_pkg::*;

	// configuration registers
	logic signed [W-1:0] center_re_q, center_im_q, flow_cos_q, flow_sin_q, circ_k_q;
	logic [W-2:0]        radius_sq_q;

	logic en;
	logic v_s1, v_s2, v_s3;

	logic signed [WD_W-1:0]   wx_s1, wy_s1;
	logic signed [M2_W-1:0]   sqx_s2, sqy_s2;
	logic signed [2*W:0]      uxwy_s2, uywx_s2;
	logic [M2_W-1:0]          m2_s3;
	logic signed [M2_W-1:0]   d_s3;
	logic signed [M2_W:0]     fac_s3;
	logic                     zero_s3;
	logic [M2_W-1:0]          m2_sum;

	cfsf_ctl_t     ctl;
	cfsf_flow_in_t flow_in;
	cfsf_log_in_t  log_in;
	cfsf_log_out_t log_out;

	logic                     flow_valid;
	logic signed [FLOW_W-1:0] flow;

	logic signed [LOGT_W-1:0] algn_logt_s [1:ALIGN];
	logic                     algn_zero_s [1:ALIGN];

	logic signed [SUM_W-1:0]  sum;

	logic                     res_valid_q;
	logic signed [W-1:0]      res_value_q;
	logic                     res_center_q, res_clip_q;

	// register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_re_q <= '0;
			center_im_q <= '0;
			radius_sq_q <= (W-1)'(1 << FRAC_BITS);
			flow_cos_q  <= W'(1 << FRAC_BITS);
			flow_sin_q  <= '0;
			circ_k_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CENTER_RE: center_re_q <= cfg_data;
				REG_CENTER_IM: center_im_q <= cfg_data;
				REG_RADIUS_SQ: radius_sq_q <= cfg_data[W-2:0];
				REG_FLOW_COS:  flow_cos_q  <= cfg_data;
				REG_FLOW_SIN:  flow_sin_q  <= cfg_data;
				REG_CIRC_K:    circ_k_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipe moves when the output slot frees up
	assign en           = !res_valid_q || result.ready;
	assign point.ready  = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= point.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign m2_sum = M2_W'(sqx_s2) + M2_W'(sqy_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1   <= WD_W'(point.point_re) - WD_W'(center_re_q);
			wy_s1   <= WD_W'(point.point_im) - WD_W'(center_im_q);
			sqx_s2  <= wx_s1 * wx_s1;
			sqy_s2  <= wy_s1 * wy_s1;
			uxwy_s2 <= flow_cos_q * wy_s1;
			uywx_s2 <= flow_sin_q * wx_s1;
			m2_s3   <= m2_sum;
			zero_s3 <= (m2_sum == '0);
			d_s3    <= M2_W'(uxwy_s2) - M2_W'(uywx_s2);
			fac_s3  <= $signed({1'b0, m2_sum})
			           - $signed((M2_W+1)'({radius_sq_q, {FRAC_BITS{1'b0}}}));
		end
	end

	assign ctl.en      = en;
	assign ctl.valid   = v_s3;
	assign flow_in.m2  = m2_s3;
	assign flow_in.d   = d_s3;
	assign flow_in.fac = fac_s3;
	assign log_in.m2   = m2_s3;
	assign log_in.zero = zero_s3;

	cfsf_flow u_flow (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.din    (flow_in),
		.valid  (flow_valid),
		.flow   (flow)
	);

	cfsf_log u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.circ_k (circ_k_q),
		.din    (log_in),
		.dout   (log_out)
	);

	// delay the shorter log path to line up with the divider
	always_ff @(posedge clk) begin
		if (en) begin
			algn_logt_s[1] <= log_out.logt;
			algn_zero_s[1] <= log_out.zero;
			for (int j = 1; j < ALIGN; j++) begin
				algn_logt_s[j+1] <= algn_logt_s[j];
				algn_zero_s[j+1] <= algn_zero_s[j];
			end
		end
	end

	assign sum = SUM_W'(flow) + SUM_W'(algn_logt_s[ALIGN]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= flow_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (algn_zero_s[ALIGN]) begin
				res_value_q  <= '0;
				res_center_q <= 1'b1;
				res_clip_q   <= 1'b0;
			end else if (sum > SUM_W'(OUT_MAX)) begin
				res_value_q  <= OUT_MAX;
				res_center_q <= 1'b0;
				res_clip_q   <= 1'b1;
			end else if (sum < SUM_W'(OUT_MIN)) begin
				res_value_q  <= OUT_MIN;
				res_center_q <= 1'b0;
				res_clip_q   <= 1'b1;
			end else begin
				res_value_q  <= sum[W-1:0];
				res_center_q <= 1'b0;
				res_clip_q   <= 1'b0;
			end
		end
	end

	assign result.valid        = res_valid_q;
	assign result.stream_value = res_value_q;
	assign result.at_center    = res_center_q;
	assign result.clipped      = res_clip_q;

	a_center_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.at_center |-> result.stream_value == '0 && !result.clipped)
		else $error("center word not zeroed");

	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.clipped
		|-> result.stream_value == OUT_MAX || result.stream_value == OUT_MIN)
		else $error("clipped word not at a rail");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s3) && $stable(flow_valid))
		else $error("pipe moved during stall");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(flow_valid))
		else $error("result word without pipe word");

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top - testbench for cylinder_flow_stream_function_top
// Streams grid points through the block under several register settings,
// predicts each stream function word in fixed point and compares every
// result word in order. Both channel sides stall at random.
// ----------------------------------------------------------------------------
module tb_top;
	import cfsf_pkg::*;

	localparam logic [2:0] REG_UNUSED = 3'd7;   // index with no register behind it
	localparam int DRAIN_CYCLES = 80;           // beyond the pipeline depth

	typedef struct {
		logic signed [23:0] value;
		logic               at_center;
		logic               clipped;
	} psi_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;

	cfsf_point_if  pt();
	cfsf_result_if res();

	cylinder_flow_stream_function_top u_dut (
		.clk(clk), .arst_n(arst_n), .point(pt.sink), .result(res.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow of the register file
	logic signed [23:0] c_re, c_im, u_cos, u_sin, circ_k;
	logic        [22:0] r_sq;

	psi_word_t psi_queue[$];
	int errors = 0;

	initial begin
		pt.valid = 1'b0;
		pt.point_re = '0;
		pt.point_im = '0;
		res.ready = 1'b0;
	end

	initial forever #10 clk = ~clk;

	// hard stop well past the slowest legal run
	initial begin
		#60000000;
		$display("tb_top failed");
		$finish;
	end

	// ln of m2/2^32 with 24 fraction bits: normalize, then square-and-compare
	function automatic longint ln_q24(logic [63:0] m2);
		int e;
		logic [63:0] m;
		longint frac, lg;
		e = 63;
		while (!m2[e]) e--;
		m = (e >= 30) ? (m2 >> (e - 30)) : (m2 << (30 - e));
		frac = 0;
		for (int i = 0; i < 24; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd2 << 30)) begin
				frac = frac | 1;
				m = m >> 1;
			end
		end
		lg = longint'(e - 2 * FRAC_BITS) * (longint'(1) <<< 24) + frac;
		return (lg * longint'(744261118)) / (longint'(1) <<< 30);
	endfunction

	function automatic psi_word_t stream_fn(logic signed [23:0] p_re, logic signed [23:0] p_im);
		psi_word_t o;
		longint wx, wy, m2, d, fac, flow, logt, sum;
		logic [127:0] prod, q;
		logic [63:0] dm, fm, mag;
		bit neg;
		wx = longint'(p_re) - longint'(c_re);
		wy = longint'(p_im) - longint'(c_im);
		m2 = wx * wx + wy * wy;
		o.value = '0;
		o.at_center = 1'b0;
		o.clipped = 1'b0;
		if (m2 == 0) begin
			o.at_center = 1'b1;
			return o;
		end
		d = longint'(u_cos) * wy - longint'(u_sin) * wx;
		fac = m2 - (longint'(r_sq) <<< FRAC_BITS);
		neg = (d < 0) != (fac < 0);
		dm = (d < 0) ? -d : d;
		fm = (fac < 0) ? -fac : fac;
		prod = {64'd0, dm} * {64'd0, fm};
		q = (prod / {64'd0, m2}) >> FRAC_BITS;
		mag = (q > (128'd1 << 40)) ? (64'd1 << 40) : q[63:0];
		flow = neg ? -longint'(mag) : longint'(mag);
		logt = (longint'(circ_k) * ln_q24(m2)) / (longint'(1) <<< 25);
		sum = flow + logt;
		if (sum > 8388607) begin
			sum = 8388607;
			o.clipped = 1'b1;
		end else if (sum < -8388608) begin
			sum = -8388608;
			o.clipped = 1'b1;
		end
		o.value = sum[23:0];
		return o;
	endfunction

	// receive side: random backpressure, compare each taken word with the oldest prediction
	initial begin
		int stall;
		bit took;
		psi_word_t got, want;
		stall = 0;
		forever begin
			@(negedge clk);
			took = res.valid && res.ready;
			got.value = res.stream_value;
			got.at_center = res.at_center;
			got.clipped = res.clipped;
			@(posedge clk);
			if (took) begin
				if (psi_queue.size() == 0) begin
					$display("%0t: unexpected word value=%0d", $time, got.value);
					errors++;
				end else begin
					want = psi_queue.pop_front();
					if (got.value !== want.value) begin
						$display("%0t: stream_value expected %0d actual %0d",
							$time, want.value, got.value);
						errors++;
					end
					if (got.at_center !== want.at_center) begin
						$display("%0t: at_center expected %0b actual %0b",
							$time, want.at_center, got.at_center);
						errors++;
					end
					if (got.clipped !== want.clipped) begin
						$display("%0t: clipped expected %0b actual %0b",
							$time, want.clipped, got.clipped);
						errors++;
					end
				end
			end
			// mostly ready; short stalls often, a long one now and then
			if (stall > 0) begin
				stall--;
			end else if ($urandom_range(0, 99) < 15) begin
				stall = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120)
					: $urandom_range(1, 4);
			end
			res.ready <= (stall == 0);
		end
	end

	// push one point word; valid is held high across back-to-back words
	task automatic send_point(logic signed [23:0] p_re, logic signed [23:0] p_im);
		int gap;
		bit rdy;
		gap = 0;
		if ($urandom_range(0, 99) < 30) begin
			gap = ($urandom_range(0, 24) == 0) ? $urandom_range(15, 100)
				: $urandom_range(1, 3);
		end
		if (gap > 0) begin
			pt.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pt.valid <= 1'b1;
		pt.point_re <= p_re;
		pt.point_im <= p_im;
		do begin
			@(negedge clk);
			rdy = pt.ready;
			@(posedge clk);
		end while (!rdy);
		psi_queue.push_back(stream_fn(p_re, p_im));
	endtask

	task automatic wait_idle();
		pt.valid <= 1'b0;
		while (psi_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [23:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CENTER_RE: c_re = val;
			REG_CENTER_IM: c_im = val;
			REG_RADIUS_SQ: r_sq = val[22:0];
			REG_FLOW_COS:  u_cos = val;
			REG_FLOW_SIN:  u_sin = val;
			REG_CIRC_K:    circ_k = val;
			default: ;
		endcase
	endtask

	task automatic write_all(logic [23:0] cre, logic [23:0] cim, logic [23:0] rsq,
		logic [23:0] uc, logic [23:0] us, logic [23:0] k);
		write_reg(REG_CENTER_RE, cre);
		write_reg(REG_CENTER_IM, cim);
		write_reg(REG_RADIUS_SQ, rsq);
		write_reg(REG_FLOW_COS, uc);
		write_reg(REG_FLOW_SIN, us);
		write_reg(REG_CIRC_K, k);
	endtask

	// a point: exactly on the centre, near it, or anywhere in range
	task automatic send_random_point();
		int sel;
		logic signed [23:0] re, im;
		sel = $urandom_range(0, 99);
		if (sel < 4) begin
			re = c_re;
			im = c_im;
		end else if (sel < 60) begin
			re = c_re + 24'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
			im = c_im + 24'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
		end else begin
			re = 24'($urandom);
			im = 24'($urandom);
		end
		send_point(re, im);
	endtask

	// reset defaults, field extremes, centre point, radius and saturation
	task automatic test_directed();
		send_point(24'sd0, 24'sd0);                 // centre at reset
		send_point(24'sh7fffff, 24'sh7fffff);
		send_point(24'sh800000, 24'sh800000);
		send_point(24'sh7fffff, 24'sh800000);
		send_point(24'sh800000, 24'sh7fffff);
		send_point(24'sd65536, 24'sd0);             // on the circle
		send_point(24'sd0, 24'sd65536);
		send_point(24'sd1, 24'sd0);                 // tiny |w|, flow term huge
		send_point(24'sd0, -24'sd1);
		send_point(24'sd32768, 24'sd16384);
		wait_idle();
		write_reg(REG_UNUSED, 24'hffffff);          // must be ignored
		write_all(24'h7fffff, 24'h800000, 24'h7fffff, 24'h7fffff, 24'h800000, 24'h7fffff);
		send_point(24'sh7fffff, 24'sh800000);       // centre at the extremes
		send_point(24'sh800000, 24'sh7fffff);
		send_point(24'sh7ffffe, 24'sh800000);
		send_point(24'sd0, 24'sd0);
		send_point(24'sh7fffff, 24'sh7fffff);
		wait_idle();
		write_all(24'h800000, 24'h7fffff, 24'h000000, 24'h800000, 24'h7fffff, 24'h800000);
		send_point(24'sh800000, 24'sh7fffff);
		send_point(24'sh800001, 24'sh7fffff);
		send_point(24'sh7fffff, 24'sh800000);
		send_point(24'sd0, 24'sd0);
		send_point(24'sh800000, 24'sh7ffff0);
		wait_idle();
	endtask

	// random register settings, a few of them extreme, random points each
	task automatic test_random_settings();
		logic [23:0] v[6];
		for (int ph = 0; ph < 10; ph++) begin
			for (int i = 0; i < 6; i++) begin
				case ($urandom_range(0, 5))
					0: v[i] = 24'h7fffff;
					1: v[i] = 24'h800000;
					2: v[i] = 24'h000000;
					3: v[i] = 24'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
					default: v[i] = 24'($urandom);
				endcase
			end
			write_all(v[0], v[1], v[2], v[3], v[4], v[5]);
			for (int n = 0; n < 155; n++) send_random_point();
			wait_idle();
		end
	endtask

	// sender holds off until the pipe has fully drained, then bursts
	task automatic test_drain_pause();
		write_all(24'h010000, 24'hff8000, 24'h020000, 24'h00b505, 24'h00b505, 24'h018000);
		for (int b = 0; b < 4; b++) begin
			for (int n = 0; n < 20; n++) send_random_point();
			pt.valid <= 1'b0;
			while (psi_queue.size() != 0) @(posedge clk);
		end
		wait_idle();
	endtask

	initial begin
		int guard;
		c_re = '0; c_im = '0; r_sq = 23'd65536;
		u_cos = 24'sd65536; u_sin = '0; circ_k = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_settings();
		test_drain_pause();
		guard = 0;
		while (psi_queue.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && psi_queue.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

/* sim.f */
sv/cfsf_pkg.sv
sv/cfsf_ifs.sv
sv/cfsf_flow.sv
sv/cfsf_log.sv
sv/cylinder_flow_stream_function_top.sv
bench/tb_top.sv
